// File: design/fmbq_pkg.sv
package fmbq_pkg;

    // Defaults for the top level parameters
    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed port field widths
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 11;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_MIDDLE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_MIDDLE  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_POP_BACK    = 3'd5;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Memory action plan for one word, built at accept time
    typedef struct packed {
        status_t status;
        logic    f_wr;         // write word into front half at accept
        logic    b_wr;         // write word into back half at accept
        logic    pop;          // read at accept returns the popped word
        logic    pop_from_b;   // popped word comes from the back half
        logic    move;         // one word moves between halves
        logic    move_from_b;  // move source is the back half (else front)
        logic    mv_early;     // move source read issued at accept
        logic    post_wr;      // word written into back half with the move
    } plan_t;

endpackage

// File: design/fmbq_ram.sv
module fmbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fmbq_plan.sv
module fmbq_plan #(
    parameter int CAPACITY = fmbq_pkg::CAPACITY_DEF,
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2,
    localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic [fmbq_pkg::FUNC_W-1:0] func,
    input  logic [AW-1:0]               fs,
    input  logic [AW-1:0]               bs,
    input  logic [CW-1:0]               count,
    output fmbq_pkg::plan_t             plan,
    output logic [AW-1:0]               f_waddr,
    output logic [AW-1:0]               b_waddr,
    output logic [AW-1:0]               rd_addr,
    output logic [AW-1:0]               mv_src,
    output logic [AW-1:0]               mv_dst,
    output logic [AW-1:0]               post_addr,
    output logic [AW-1:0]               fs_next,
    output logic [AW-1:0]               bs_next,
    output logic [CW-1:0]               count_next
);

    import fmbq_pkg::*;

    localparam logic [AW:0]   HD_W    = (AW + 1)'(HALF_DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(HALF_DEPTH - 1);

    // Physical index of logical offset off from start s
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] s, input logic [AW:0] off);
        logic [AW:0] sum;
        sum = {1'b0, s} + off;
        if (sum >= HD_W)
        begin
            sum = sum - HD_W;
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] dec_ix(input logic [AW-1:0] x);
        return (x == '0) ? LAST_IX : x - 1'b1;
    endfunction

    function automatic logic [AW-1:0] inc_ix(input logic [AW-1:0] x);
        return (x == LAST_IX) ? '0 : x + 1'b1;
    endfunction

    logic [AW:0] fc;
    logic [AW:0] bc;
    logic        odd;
    logic        full;
    logic        empty;
    logic        is_push;
    logic        is_pop;

    // Front half holds floor(n/2) words, back half the rest
    assign fc      = (AW + 1)'(count >> 1);
    assign bc      = (AW + 1)'(count - (count >> 1));
    assign odd     = count[0];
    assign full    = (count == CW'(CAPACITY));
    assign empty   = (count == '0);
    assign is_push = func inside {FN_PUSH_FRONT, FN_PUSH_MIDDLE, FN_PUSH_BACK};
    assign is_pop  = func inside {FN_POP_FRONT, FN_POP_MIDDLE, FN_POP_BACK};

    // Decode operation into accesses and a rebalancing move
    always_comb
    begin
        plan       = '0;
        plan.status = ST_OK;
        f_waddr    = '0;
        b_waddr    = '0;
        rd_addr    = '0;
        mv_src     = '0;
        mv_dst     = '0;
        post_addr  = '0;
        fs_next    = fs;
        bs_next    = bs;
        count_next = count;
        if (is_push && full)
        begin
            plan.status = ST_FULL;
        end
        else if (is_pop && empty)
        begin
            plan.status = ST_EMPTY;
        end
        else
        begin
            case (func)
                FN_PUSH_FRONT:
                begin
                    plan.f_wr  = 1'b1;
                    f_waddr    = dec_ix(fs);
                    fs_next    = dec_ix(fs);
                    count_next = count + 1'b1;
                    if (!odd)
                    begin
                        // front grew past half: its last word goes to back front
                        plan.move = 1'b1;
                        mv_src    = slot(dec_ix(fs), fc);
                        mv_dst    = dec_ix(bs);
                        bs_next   = dec_ix(bs);
                    end
                end
                FN_PUSH_MIDDLE:
                begin
                    plan.f_wr  = 1'b1;
                    f_waddr    = slot(fs, fc);
                    count_next = count + 1'b1;
                    if (!odd)
                    begin
                        plan.move = 1'b1;
                        mv_src    = slot(fs, fc);
                        mv_dst    = dec_ix(bs);
                        bs_next   = dec_ix(bs);
                    end
                end
                FN_PUSH_BACK:
                begin
                    count_next = count + 1'b1;
                    if (odd)
                    begin
                        // back front moves to front tail, then word lands at back tail
                        plan.move        = 1'b1;
                        plan.move_from_b = 1'b1;
                        plan.mv_early    = 1'b1;
                        plan.post_wr     = 1'b1;
                        rd_addr          = bs;
                        mv_dst           = slot(fs, fc);
                        post_addr        = slot(bs, bc);
                        bs_next          = inc_ix(bs);
                    end
                    else
                    begin
                        plan.b_wr = 1'b1;
                        b_waddr   = slot(bs, bc);
                    end
                end
                FN_POP_FRONT:
                begin
                    plan.pop   = 1'b1;
                    count_next = count - 1'b1;
                    if (fc != '0)
                    begin
                        rd_addr = fs;
                        fs_next = inc_ix(fs);
                        if (odd)
                        begin
                            plan.move        = 1'b1;
                            plan.move_from_b = 1'b1;
                            mv_src           = bs;
                            mv_dst           = slot(fs, fc);
                            bs_next          = inc_ix(bs);
                        end
                    end
                    else
                    begin
                        // single word lives in the back half
                        plan.pop_from_b = 1'b1;
                        rd_addr         = bs;
                        bs_next         = inc_ix(bs);
                    end
                end
                FN_POP_MIDDLE:
                begin
                    plan.pop   = 1'b1;
                    count_next = count - 1'b1;
                    if (odd)
                    begin
                        plan.pop_from_b = 1'b1;
                        rd_addr         = bs;
                        bs_next         = inc_ix(bs);
                    end
                    else
                    begin
                        rd_addr = slot(fs, fc - 1'b1);
                    end
                end
                FN_POP_BACK:
                begin
                    plan.pop        = 1'b1;
                    plan.pop_from_b = 1'b1;
                    count_next      = count - 1'b1;
                    rd_addr         = slot(bs, bc - 1'b1);
                    if (!odd)
                    begin
                        plan.move = 1'b1;
                        mv_src    = slot(fs, fc - 1'b1);
                        mv_dst    = dec_ix(bs);
                        bs_next   = dec_ix(bs);
                    end
                end
                default:
                begin
                    plan.status = ST_OK;
                end
            endcase
        end
    end

endmodule

// File: design/front_middle_back_queue_core.sv
// Front/middle/back queue of up to CAPACITY words. Each input word carries an
// operation (push front, middle or back; pop front, middle or back) and returns
// exactly one result word with the popped value, a status (ok, pop on empty,
// push on full) and the occupancy after the operation. Contents sit in two
// circular half stores, front and back, each a one-port-read RAM with a
// registered read; after every operation at most one word moves between
// them so the front half holds floor(n/2) words. One operation is worked at a
// time, from accept to the done step: rejected operations, unused codes and
// pushes that need no move go straight to done; a pop with no move reads at
// accept and takes its word in the read step; a push back that moves a word
// issues the move read at accept and then writes the move; a push front or
// middle with a move and a pop with a move make the first access at accept,
// then the move read, then the move write. A finished result sits in an output
// register, so the next operation is taken while it waits; that operation then
// holds in its done step until the register is free. The stores are not cleared
// at reset; only written entries are ever read.
module front_middle_back_queue_core #(
    parameter int CAPACITY   = fmbq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fmbq_pkg::FUNC_W-1:0]   func,
    input  logic [fmbq_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fmbq_pkg::VALUE_W-1:0]  result_value,
    output logic [fmbq_pkg::STATUS_W-1:0] status,
    output logic [fmbq_pkg::OCC_W-1:0]    occupancy
);

    import fmbq_pkg::*;

    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD2  = 4'b0010,
        S_MVWR = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    plan_t                 plan_reg;
    logic [AW-1:0]         fs_reg, bs_reg;
    logic [CW-1:0]         cnt_reg;
    logic [AW-1:0]         mv_src_reg, mv_dst_reg, post_addr_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [VALUE_W-1:0]    res_reg;

    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    result_out_reg;
    status_t               status_out_reg;
    logic [OCC_W-1:0]      occ_out_reg;

    plan_t                 plan;
    logic [AW-1:0]         p_f_waddr, p_b_waddr, p_rd_addr;
    logic [AW-1:0]         p_mv_src, p_mv_dst, p_post_addr;
    logic [AW-1:0]         fs_next, bs_next;
    logic [CW-1:0]         cnt_next;

    logic                  accept;
    logic                  load_out;
    logic                  f_we, b_we;
    logic [AW-1:0]         f_waddr, b_waddr, raddr;
    logic [DATA_WIDTH-1:0] f_wdata, b_wdata, f_rdata, b_rdata;
    logic [DATA_WIDTH-1:0] in_word;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign in_word  = DATA_WIDTH'(value);

    fmbq_plan #(
        .CAPACITY (CAPACITY)
    ) u_plan (
        .func       (func),
        .fs         (fs_reg),
        .bs         (bs_reg),
        .count      (cnt_reg),
        .plan       (plan),
        .f_waddr    (p_f_waddr),
        .b_waddr    (p_b_waddr),
        .rd_addr    (p_rd_addr),
        .mv_src     (p_mv_src),
        .mv_dst     (p_mv_dst),
        .post_addr  (p_post_addr),
        .fs_next    (fs_next),
        .bs_next    (bs_next),
        .count_next (cnt_next)
    );

    // Memory port steering: accept-time access, then the move
    // Writes land before any read of the same entry, so no bypass.
    always_comb
    begin
        raddr   = (state_reg == S_IDLE) ? p_rd_addr : mv_src_reg;
        f_we    = (accept && plan.f_wr)
                  || ((state_reg == S_MVWR) && plan_reg.move_from_b);
        f_waddr = (state_reg == S_MVWR) ? mv_dst_reg : p_f_waddr;
        f_wdata = (state_reg == S_MVWR) ? b_rdata : in_word;
        b_we    = (accept && plan.b_wr)
                  || ((state_reg == S_MVWR) && (!plan_reg.move_from_b || plan_reg.post_wr));
        if (state_reg == S_MVWR)
        begin
            b_waddr = plan_reg.move_from_b ? post_addr_reg : mv_dst_reg;
            b_wdata = plan_reg.move_from_b ? value_reg : f_rdata;
        end
        else
        begin
            b_waddr = p_b_waddr;
            b_wdata = in_word;
        end
    end

    fmbq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (HALF_DEPTH)
    ) u_front_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (raddr),
        .rdata (f_rdata)
    );

    fmbq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (HALF_DEPTH)
    ) u_back_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (raddr),
        .rdata (b_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (plan.pop || (plan.move && !plan.mv_early))
                    begin
                        state_next = S_RD2;
                    end
                    else if (plan.mv_early)
                    begin
                        state_next = S_MVWR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RD2:
            begin
                state_next = plan_reg.move ? S_MVWR : S_DONE;
            end
            S_MVWR:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: pointers, count, plan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            plan_reg  <= '0;
            fs_reg    <= '0;
            bs_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                plan_reg <= plan;
                fs_reg   <= fs_next;
                bs_reg   <= bs_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // Per-operation payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mv_src_reg    <= p_mv_src;
            mv_dst_reg    <= p_mv_dst;
            post_addr_reg <= p_post_addr;
            value_reg     <= in_word;
            res_reg       <= '0;
        end
        else if ((state_reg == S_RD2) && plan_reg.pop)
        begin
            res_reg <= VALUE_W'(plan_reg.pop_from_b ? b_rdata : f_rdata);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_out_reg <= res_reg;
            status_out_reg <= plan_reg.status;
            occ_out_reg    <= OCC_W'(cnt_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_out_reg;
    assign status       = status_out_reg;
    assign occupancy    = occ_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("word count above capacity");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && plan.status == ST_FULL) |=> (cnt_reg == $past(cnt_reg)))
        else $error("rejected push changed the count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && plan.pop) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("pop did not drop the count by one");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_out_reg == ST_EMPTY) |-> (result_out_reg == '0))
        else $error("empty pop returned a nonzero word");

endmodule

// File: tb/fmbq_checker.sv
module fmbq_checker #(
    parameter int CAPACITY = fmbq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [fmbq_pkg::FUNC_W-1:0]   func,
    input  logic [fmbq_pkg::VALUE_W-1:0]  value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [fmbq_pkg::VALUE_W-1:0]  result_value,
    input  logic [fmbq_pkg::STATUS_W-1:0] status,
    input  logic [fmbq_pkg::OCC_W-1:0]    occupancy,
    output int                            fail_count,
    output int                            awaited_count,
    output int                            checked_count,
    output int                            full_rejects,
    output int                            empty_rejects,
    output int                            peak_level
);
    timeunit 1ns;
    timeprecision 1ps;

    import fmbq_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] word;
        status_t            st;
        logic [OCC_W-1:0]   occ;
    } op_result_t;

    // queue contents, index 0 is the front
    logic [VALUE_W-1:0] held_words[$];
    // predicted results not yet returned
    op_result_t         awaited_results[$];

    // Apply one operation to the held words and return what the block owes
    function automatic op_result_t apply_queue_op(input logic [FUNC_W-1:0] op,
                                                  input logic [VALUE_W-1:0] word);
        op_result_t r;
        int         n;
        int         mid;
        n      = held_words.size();
        r.word = '0;
        r.st   = ST_OK;
        if (op == FN_PUSH_FRONT || op == FN_PUSH_MIDDLE || op == FN_PUSH_BACK)
        begin
            if (n >= CAPACITY)
                r.st = ST_FULL;
            else if (op == FN_PUSH_FRONT)
                held_words.push_front(word);
            else if (op == FN_PUSH_MIDDLE)
                held_words.insert(n / 2, word);
            else
                held_words.push_back(word);
        end
        else if (op == FN_POP_FRONT || op == FN_POP_MIDDLE || op == FN_POP_BACK)
        begin
            if (n == 0)
                r.st = ST_EMPTY;
            else if (op == FN_POP_FRONT)
                r.word = held_words.pop_front();
            else if (op == FN_POP_BACK)
                r.word = held_words.pop_back();
            else
            begin
                mid    = (n - 1) / 2;
                r.word = held_words[mid];
                held_words.delete(mid);
            end
        end
        // unused codes leave everything alone
        r.occ = OCC_W'(held_words.size());
        return r;
    endfunction

    // Compare returned words first, then predict the word taken at this edge
    always @(posedge clk)
    begin : watch
        op_result_t want;
        op_result_t got;
        if (!rst_n)
        begin
            held_words.delete();
            awaited_results.delete();
            fail_count    = 0;
            awaited_count = 0;
            checked_count = 0;
            full_rejects  = 0;
            empty_rejects = 0;
            peak_level    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.word = result_value;
                got.st   = status_t'(status);
                got.occ  = occupancy;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word with nothing pending:", $time,
                                 " value %h status %0d occupancy %0d",
                                 got.word, got.st, got.occ);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    checked_count++;
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch: expected value %h status %0d",
                                     $time, want.word, want.st,
                                     " occupancy %0d, got value %h status %0d",
                                     want.occ, got.word, got.st,
                                     " occupancy %0d", got.occ);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = apply_queue_op(func, value);
                if (want.st == ST_FULL)
                    full_rejects++;
                if (want.st == ST_EMPTY)
                    empty_rejects++;
                if (held_words.size() > peak_level)
                    peak_level = held_words.size();
                awaited_results.push_back(want);
            end
            awaited_count = awaited_results.size();
        end
    end

endmodule

// File: tb/front_middle_back_queue_core_tb.sv
module front_middle_back_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmbq_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    // codes the block must ignore
    localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [FUNC_W-1:0]   func;
    logic [VALUE_W-1:0]  value;
    logic                out_valid;
    logic                out_ready;
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    int fail_count;
    int awaited_count;
    int checked_count;
    int full_rejects;
    int empty_rejects;
    int peak_level;

    int sent_count = 0;
    int level      = 0;     // words held, tracked on the send side
    bit send_burst = 0;
    bit recv_burst = 0;

    front_middle_back_queue_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    fmbq_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .status        (status),
        .occupancy     (occupancy),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .checked_count (checked_count),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects),
        .peak_level    (peak_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one word: optional gap first, then hold valid until taken
    task automatic send_word(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] word);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            func     <= FUNC_W'($urandom);
            value    <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        value    <= word;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_count++;
        if (op == FN_PUSH_FRONT || op == FN_PUSH_MIDDLE || op == FN_PUSH_BACK)
        begin
            if (level < CAPACITY)
                level++;
        end
        else if (op == FN_POP_FRONT || op == FN_POP_MIDDLE || op == FN_POP_BACK)
        begin
            if (level > 0)
                level--;
        end
        if (sent_count % 64 == 0)
            send_burst = ($urandom_range(0, 3) == 0);
    endtask

    // push_pct percent pushes, a few unused codes, the rest pops
    function automatic logic [FUNC_W-1:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return ($urandom_range(0, 1) == 0) ? FN_UNUSED_A : FN_UNUSED_B;
        else if (r < 2 + push_pct)
            return FN_PUSH_FRONT + FUNC_W'($urandom_range(0, 2));
        else
            return FN_POP_FRONT + FUNC_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall before each word, bursts with none
    initial
    begin : result_side
        int stall;
        int taken;
        out_ready = 1'b0;
        taken     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 50 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
            taken++;
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int i;
        in_valid  = 1'b0;
        func      = '0;
        value     = '0;
        rst_n     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pops on an empty queue and the ignored codes
        send_word(FN_POP_FRONT, 32'h1234_5678);
        send_word(FN_POP_MIDDLE, '1);
        send_word(FN_POP_BACK, '0);
        send_word(FN_UNUSED_A, 32'hDEAD_BEEF);
        send_word(FN_UNUSED_B, '1);
        // build a short queue with every push kind and extreme words
        send_word(FN_PUSH_BACK, '1);
        send_word(FN_PUSH_FRONT, '0);
        send_word(FN_PUSH_MIDDLE, 32'hA5A5_A5A5);
        send_word(FN_PUSH_MIDDLE, 32'h5A5A_5A5A);
        send_word(FN_PUSH_BACK, 32'h0000_0001);
        send_word(FN_PUSH_FRONT, 32'h8000_0000);
        // take it apart from odd and even sizes
        send_word(FN_POP_MIDDLE, '0);
        send_word(FN_POP_MIDDLE, '0);
        send_word(FN_POP_FRONT, '0);
        send_word(FN_POP_BACK, '0);
        send_word(FN_POP_MIDDLE, '0);
        send_word(FN_POP_BACK, '0);
        // single-word queue: front pop comes from the back half
        send_word(FN_PUSH_MIDDLE, 32'hC001_D00D);
        send_word(FN_POP_FRONT, '0);
        send_word(FN_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(FN_POP_BACK, '0);
        send_word(FN_PUSH_BACK, 32'hFFFF_FFFE);
        send_word(FN_POP_MIDDLE, '0);

        // shallow mixed traffic, empty often
        for (i = 0; i < 250; i++)
            send_word(pick_op(50), pick_value());
        // fill to capacity
        while (level < CAPACITY)
            send_word(pick_op(95), pick_value());
        // every push kind on a full queue, then churn at the boundary
        send_word(FN_PUSH_FRONT, pick_value());
        send_word(FN_PUSH_MIDDLE, pick_value());
        send_word(FN_PUSH_BACK, pick_value());
        for (i = 0; i < 40; i++)
            send_word(pick_op(70), pick_value());
        // drain part way, pops dominate
        for (i = 0; i < 350; i++)
            send_word(pick_op(20), pick_value());
        in_valid <= 1'b0;

        // wait for outstanding results, then a few more cycles
        for (i = 0; i < 5000 && awaited_count != 0; i++)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Covered %0d operations, %0d results checked, peak occupancy %0d of %0d.",
                 sent_count, checked_count, peak_level, CAPACITY);
        $display("Rejected %0d pushes on a full queue and %0d pops on an empty queue.",
                 full_rejects, empty_rejects);
        if (awaited_count != 0)
            $display("%0d results never arrived", awaited_count);
        if (fail_count == 0 && awaited_count == 0)
            $display("** front_middle_back_queue_core: PASSED **");
        else
            $display("** front_middle_back_queue_core: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout after %0d operations sent", sent_count);
        $display("** front_middle_back_queue_core: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
design/fmbq_pkg.sv
design/fmbq_ram.sv
design/fmbq_plan.sv
design/front_middle_back_queue_core.sv
tb/fmbq_checker.sv
tb/front_middle_back_queue_core_tb.sv
